// File: rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, quiet while reset is held
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs during reset
`define ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/bas_pkg.sv
`timescale 1ns / 1ps

package bas_pkg;

    // Default geometry of the bit store
    localparam int BITS_DEF      = 4096;
    localparam int WORD_BITS_DEF = 64;

    // Fixed field widths
    localparam int IDX_W   = 12;
    localparam int TALLY_W = 13;
    localparam int CFG_W   = 13;

    // Command codes
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_SIEVE = 2'd3
    } t_cmd;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_RW,
        ST_RW_RD,
        ST_RW_DO,
        ST_SI_TEST,
        ST_DIV_I,
        ST_SI_IRD,
        ST_SI_ICHK,
        ST_DIV_J,
        ST_SI_MRD,
        ST_SI_MWR,
        ST_SI_NORM,
        ST_SCAN_RD,
        ST_SCAN_BIT,
        ST_FINISH
    } t_state;

    // One result item
    typedef struct packed {
        logic               read_bit;
        logic [TALLY_W-1:0] tally;
        logic               status;
    } t_result;

endpackage

// File: rtl/core/bas_store.sv
`timescale 1ns / 1ps

module bas_store
    import bas_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int DEPTH     = BITS_DEF / WORD_BITS_DEF,
    parameter int AW        = 6
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_addr,
    input  logic [WORD_BITS-1:0] i_wdata,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    // Single port, registered read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bas_divmod.sv
`timescale 1ns / 1ps

module bas_divmod
    import bas_pkg::*;
#(
    parameter int LW = CFG_W,
    parameter int AW = $clog2(BITS_DEF / WORD_BITS_DEF),
    parameter int BW = $clog2(WORD_BITS_DEF)
) (
    input  logic          i_clk,
    input  logic          i_start,
    input  logic [LW-1:0] i_arg,
    output logic [AW-1:0] o_quo,
    output logic [BW-1:0] o_rem
);

    logic [AW-1:0] r_quo;
    logic [BW-1:0] r_rem;

    // Word size is a power of two: word address by shift, bit offset by mask
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= AW'(i_arg >> BW);
            r_rem <= i_arg[BW-1:0];
        end
    end

    assign o_quo = r_quo;
    assign o_rem = r_rem;

endmodule

// File: rtl/core/bas_seq.sv
`timescale 1ns / 1ps

module bas_seq
    import bas_pkg::*;
#(
    parameter int LW          = 13,
    parameter int WORD_BITS   = WORD_BITS_DEF,
    parameter int AW          = 6,
    parameter int BW          = 6,
    parameter int STORE_WORDS = BITS_DEF / WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command side
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_cmd                 i_cmd,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic                 i_val,
    input  logic [LW-1:0]        i_len,
    // result side
    input  logic                 i_out_free,
    output logic                 o_res_valid,
    output t_result              o_res,
    // bit store port
    output logic                 o_mem_en,
    output logic                 o_mem_we,
    output logic [AW-1:0]        o_mem_addr,
    output logic [WORD_BITS-1:0] o_mem_wdata,
    input  logic [WORD_BITS-1:0] i_mem_rdata,
    // index split
    output logic                 o_div_start,
    output logic [LW-1:0]        o_div_arg,
    input  logic [AW-1:0]        i_div_quo,
    input  logic [BW-1:0]        i_div_rem
);

    localparam int IW = (LW + 1) / 2 + 1;
    localparam int SW = LW + 2;
    localparam int OW = ((BW > IW) ? BW : IW) + 1;
    localparam int CW = (LW > IDX_W) ? LW : IDX_W;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic               r_val, n_val;
    logic               r_rd, n_rd;
    logic [TALLY_W-1:0] r_tally, n_tally;
    logic               r_status, n_status;
    logic [AW-1:0]      r_waddr, n_waddr;
    logic [BW-1:0]      r_bcnt, n_bcnt;
    logic [LW-1:0]      r_pos, n_pos;
    logic [IW-1:0]      r_i, n_i;
    logic [SW-1:0]      r_sq, n_sq;
    logic [SW-1:0]      r_j, n_j;
    logic [OW-1:0]      r_bj, n_bj;

    logic [WORD_BITS-1:0] w_mask;
    logic                 w_bit;
    logic                 w_sbit;
    logic                 w_hit;

    // Bit selected by the current cell offset, and by the scan position
    assign w_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_bj[BW-1:0];
    assign w_bit  = i_mem_rdata[r_bj[BW-1:0]];
    assign w_sbit = i_mem_rdata[r_bcnt];
    assign w_hit  = (r_cmd == CMD_COUNT) ? w_sbit : (!w_sbit && r_pos != '0);

    // Next state and outputs
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_val    = r_val;
        n_rd     = r_rd;
        n_tally  = r_tally;
        n_status = r_status;
        n_waddr  = r_waddr;
        n_bcnt   = r_bcnt;
        n_pos    = r_pos;
        n_i      = r_i;
        n_sq     = r_sq;
        n_j      = r_j;
        n_bj     = r_bj;

        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mem_en    = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_addr  = r_waddr;
        o_mem_wdata = '0;
        o_div_start = 1'b0;
        o_div_arg   = '0;

        case (r_state)
            // zero the store one word per cycle after reset
            ST_CLEAR: begin
                o_mem_en = 1'b1;
                o_mem_we = 1'b1;
                if (r_waddr == AW'(STORE_WORDS - 1)) begin
                    n_waddr = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_waddr = r_waddr + AW'(1);
                end
            end

            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd    = i_cmd;
                    n_val    = i_val;
                    n_rd     = 1'b0;
                    n_tally  = '0;
                    n_status = 1'b0;
                    case (i_cmd)
                        CMD_WRITE, CMD_READ: begin
                            if (CW'(i_idx) >= CW'(i_len)) begin
                                n_status = 1'b1;
                                n_state  = ST_FINISH;
                            end else begin
                                o_div_start = 1'b1;
                                o_div_arg   = LW'(i_idx);
                                n_state     = ST_DIV_RW;
                            end
                        end
                        CMD_COUNT: begin
                            n_waddr = '0;
                            n_bcnt  = '0;
                            n_pos   = '0;
                            n_state = (i_len == '0) ? ST_FINISH : ST_SCAN_RD;
                        end
                        CMD_SIEVE: begin
                            if (i_len < LW'(2)) begin
                                n_state = ST_FINISH;
                            end else begin
                                n_i     = IW'(2);
                                n_sq    = SW'(4);
                                n_state = ST_SI_TEST;
                            end
                        end
                        default: begin
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end

            // single cell write or read
            ST_DIV_RW: begin
                n_waddr = i_div_quo;
                n_bj    = OW'(i_div_rem);
                n_state = ST_RW_RD;
            end

            ST_RW_RD: begin
                o_mem_en = 1'b1;
                n_state  = ST_RW_DO;
            end

            ST_RW_DO: begin
                if (r_cmd == CMD_WRITE) begin
                    o_mem_en    = 1'b1;
                    o_mem_we    = 1'b1;
                    o_mem_wdata = (i_mem_rdata & ~w_mask) | (r_val ? w_mask : '0);
                end else begin
                    n_rd = w_bit;
                end
                n_state = ST_FINISH;
            end

            // sieve: next candidate while i*i is within the length
            ST_SI_TEST: begin
                if (r_sq > SW'(i_len)) begin
                    n_waddr = '0;
                    n_bcnt  = '0;
                    n_pos   = '0;
                    n_state = ST_SCAN_RD;
                end else begin
                    o_div_start = 1'b1;
                    o_div_arg   = LW'(r_i - IW'(1));
                    n_state     = ST_DIV_I;
                end
            end

            ST_DIV_I: begin
                n_waddr = i_div_quo;
                n_bj    = OW'(i_div_rem);
                n_state = ST_SI_IRD;
            end

            ST_SI_IRD: begin
                o_mem_en = 1'b1;
                n_state  = ST_SI_ICHK;
            end

            // clear cell: strike its multiples from i*i on
            ST_SI_ICHK: begin
                if (!w_bit) begin
                    o_div_start = 1'b1;
                    o_div_arg   = LW'(r_sq - SW'(1));
                    n_j         = r_sq;
                    n_state     = ST_DIV_J;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_sq    = r_sq + SW'({r_i, 1'b1});
                    n_state = ST_SI_TEST;
                end
            end

            ST_DIV_J: begin
                n_waddr = i_div_quo;
                n_bj    = OW'(i_div_rem);
                n_state = ST_SI_MRD;
            end

            ST_SI_MRD: begin
                o_mem_en = 1'b1;
                n_state  = ST_SI_MWR;
            end

            ST_SI_MWR: begin
                o_mem_en    = 1'b1;
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata | w_mask;
                n_j         = r_j + SW'(r_i);
                n_bj        = r_bj + OW'(r_i);
                n_state     = ST_SI_NORM;
            end

            // carry the bit offset into the word address, one word per cycle
            ST_SI_NORM: begin
                if (r_bj >= OW'(WORD_BITS)) begin
                    n_bj    = r_bj - OW'(WORD_BITS);
                    n_waddr = r_waddr + AW'(1);
                end else if (r_j > SW'(i_len)) begin
                    n_i     = r_i + IW'(1);
                    n_sq    = r_sq + SW'({r_i, 1'b1});
                    n_state = ST_SI_TEST;
                end else begin
                    n_state = ST_SI_MRD;
                end
            end

            // walk the cells in use, one bit per cycle, with a read at each new word
            ST_SCAN_RD: begin
                o_mem_en = 1'b1;
                n_state  = ST_SCAN_BIT;
            end

            ST_SCAN_BIT: begin
                n_tally = r_tally + TALLY_W'(w_hit);
                n_pos   = r_pos + LW'(1);
                if (r_pos + LW'(1) == i_len) begin
                    n_state = ST_FINISH;
                end else if (r_bcnt == BW'(WORD_BITS - 1)) begin
                    n_bcnt  = '0;
                    n_waddr = r_waddr + AW'(1);
                    n_state = ST_SCAN_RD;
                end else begin
                    n_bcnt = r_bcnt + BW'(1);
                end
            end

            // hand the result over once the output register is free
            ST_FINISH: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_waddr <= '0;
        end else begin
            r_state <= n_state;
            r_waddr <= n_waddr;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_val    <= n_val;
        r_rd     <= n_rd;
        r_tally  <= n_tally;
        r_status <= n_status;
        r_bcnt   <= n_bcnt;
        r_pos    <= n_pos;
        r_i      <= n_i;
        r_sq     <= n_sq;
        r_j      <= n_j;
        r_bj     <= n_bj;
    end

    assign o_res = '{read_bit: r_rd, tally: r_tally, status: r_status};

endmodule

// File: rtl/core/bit_array_with_prime_sieve.sv
`timescale 1ns / 1ps

// Bit array of BITS cells in a single-port word memory, with an in-place
// Sieve of Eratosthenes (cell k-1 stands for the number k, a clear cell
// other than cell 0 after the sieve marks a prime). One command is in
// work at a time; one result comes out per command, held in an output
// register so the next command may be taken while it waits. After reset
// the store is zeroed by a clearing pass over all STORE_WORDS words (64 at
// the defaults) before the first command is taken. WORD_BITS must be a
// power of two, which the block does not enforce; a cell index splits into
// word address and bit offset by shift and mask, registered in the divider.
// Write and read split the index, read the word, then write it back or pick
// the bit; an index at or beyond the length in use gives an error result.
// Count scans the cells in use one bit per cycle, reading each word. The
// sieve, for a length of 2 or more, reads each candidate up to sqrt(length),
// strikes multiples of each clear one by read-modify-write, then scans to
// tally the primes. The next command is taken in the cycle after its result
// is handed over, later only while the receiver leaves the output full.
module bit_array_with_prime_sieve
    import bas_pkg::*;
#(
    parameter int BITS      = BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // commands
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // [11:0] bit_index, [12] bit_value
    input  logic [1:0]       s_axis_tuser,   // [1:0] cmd
    // results
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [0] read_bit, [13:1] tally
    output logic [0:0]       m_axis_tuser,   // [0] status
    // length in use register
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int STORE_WORDS = (BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int BW          = $clog2(WORD_BITS);
    localparam int LW          = $clog2(BITS + 1);
    localparam int MW          = (LW > CFG_W) ? LW : CFG_W;

    logic [LW-1:0]        r_len;
    logic                 r_m_valid;
    t_result              r_m_res;

    logic                 w_res_valid;
    t_result              w_res;
    logic                 w_out_free;
    logic                 w_mem_en;
    logic                 w_mem_we;
    logic [AW-1:0]        w_mem_addr;
    logic [WORD_BITS-1:0] w_mem_wdata;
    logic [WORD_BITS-1:0] w_mem_rdata;
    logic                 w_div_start;
    logic [LW-1:0]        w_div_arg;
    logic [AW-1:0]        w_div_quo;
    logic [BW-1:0]        w_div_rem;

    // Length in use, saturated to the store size
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LW'(BITS);
        end else if (i_cfg_valid) begin
            r_len <= (MW'(i_cfg_data) > MW'(BITS)) ? LW'(BITS) : LW'(i_cfg_data);
        end
    end

    // Output register
    assign w_out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_res.tally, r_m_res.read_bit};
    assign m_axis_tuser  = r_m_res.status;

    bas_seq #(
        .LW          (LW),
        .WORD_BITS   (WORD_BITS),
        .AW          (AW),
        .BW          (BW),
        .STORE_WORDS (STORE_WORDS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (t_cmd'(s_axis_tuser)),
        .i_idx       (s_axis_tdata[IDX_W-1:0]),
        .i_val       (s_axis_tdata[IDX_W]),
        .i_len       (r_len),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_mem_en    (w_mem_en),
        .o_mem_we    (w_mem_we),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .i_mem_rdata (w_mem_rdata),
        .o_div_start (w_div_start),
        .o_div_arg   (w_div_arg),
        .i_div_quo   (w_div_quo),
        .i_div_rem   (w_div_rem)
    );

    bas_divmod #(
        .LW (LW),
        .AW (AW),
        .BW (BW)
    ) u_div (
        .i_clk   (i_clk),
        .i_start (w_div_start),
        .i_arg   (w_div_arg),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    bas_store #(
        .WORD_BITS (WORD_BITS),
        .DEPTH     (STORE_WORDS),
        .AW        (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (w_mem_en),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

endmodule

// File: rtl/core/bas_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bas_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [15:0]      m_axis_tdata,
    input logic [0:0]       m_axis_tuser
);

    // A stalled result holds its payload
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // One command at a time: taking a transaction drops ready
    `ASSERT_RST(a_busy_after_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready stayed high after a transaction")

    // An out-of-range index carries no read bit and no tally
    `ASSERT_RST(a_err_payload, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'h0000, "error result with nonzero data")

    // Reset empties the output register
    `ASSERT_ALW(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind bit_array_with_prime_sieve bas_checker u_bas_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: bench/tb_bit_array_with_prime_sieve.sv
`timescale 1ns / 1ps

// Bit array with in-place prime sieve: directed checks of the reset state,
// field extremes, every command and length register corner cases, sieve
// runs on a cleared range, a random mix under several idling patterns and
// back-pressure. Each result is compared with a local shadow of the bit store.
module tb_bit_array_with_prime_sieve;
    import bas_pkg::*;

    localparam int QUIET_LIMIT = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata;   // [11:0] bit_index, [12] bit_value
    logic [1:0]         s_axis_tuser;   // [1:0] cmd
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [15:0]        m_axis_tdata;   // [0] read_bit, [13:1] tally
    logic [0:0]         m_axis_tuser;   // [0] status
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data;

    // Shadow of the store and of the length register
    logic [BITS_DEF-1:0] cell_mirror;
    int unsigned         length_mirror;
    t_result             expected_results[$];

    int unsigned error_count;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned hold_request;
    int unsigned hold_left;
    int unsigned quiet_cycles;

    bit_array_with_prime_sieve dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Apply one command to the shadow store and return the result it gives
    function automatic t_result predict_outcome(t_cmd op, logic [IDX_W-1:0] idx,
                                                logic value);
        t_result     r;
        int unsigned p;
        int unsigned m;
        int unsigned n;
        r = '0;
        n = 0;
        case (op)
            CMD_WRITE: begin
                if (idx >= length_mirror) r.status = 1'b1;
                else cell_mirror[idx] = value;
            end
            CMD_READ: begin
                if (idx >= length_mirror) r.status = 1'b1;
                else r.read_bit = cell_mirror[idx];
            end
            CMD_COUNT: begin
                for (p = 0; p < length_mirror; p++)
                    if (cell_mirror[p]) n++;
                r.tally = n[TALLY_W-1:0];
            end
            default: begin
                // cell k-1 stands for k; cells already set stay composite
                if (length_mirror >= 2) begin
                    for (p = 2; p * p <= length_mirror; p++)
                        if (!cell_mirror[p-1])
                            for (m = p * p; m <= length_mirror; m += p)
                                cell_mirror[m-1] = 1'b1;
                    for (p = 2; p <= length_mirror; p++)
                        if (!cell_mirror[p-1]) n++;
                end
                r.tally = n[TALLY_W-1:0];
            end
        endcase
        return r;
    endfunction

    // Offer one command, with random idle cycles ahead of it
    task automatic send_cmd(t_cmd op, logic [IDX_W-1:0] idx, logic value);
        t_result want;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, value, idx};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want = predict_outcome(op, idx, value);
        expected_results.insert(expected_results.size(), want);
    endtask

    // Stop offering and let every outstanding result come back
    task automatic wait_drained(int unsigned settle);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_length(logic [CFG_W-1:0] value);
        wait_drained(8);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        length_mirror = (value > BITS_DEF) ? BITS_DEF : value;
    endtask

    task automatic set_idling(int unsigned src_pct, int unsigned snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // Store must come out of reset cleared, length at full size
    task automatic test_reset_state();
        send_cmd(CMD_COUNT, '0, 1'b0);
        send_cmd(CMD_READ, 12'd0, 1'b0);
        send_cmd(CMD_READ, 12'd4095, 1'b0);
    endtask

    // Index and value extremes, every index bit both ways
    task automatic test_field_extremes();
        send_cmd(CMD_WRITE, 12'd4095, 1'b1);
        send_cmd(CMD_WRITE, 12'd0, 1'b1);
        send_cmd(CMD_WRITE, 12'd2730, 1'b1);
        send_cmd(CMD_WRITE, 12'd1365, 1'b1);
        send_cmd(CMD_READ, 12'd4095, 1'b0);
        send_cmd(CMD_READ, 12'd2730, 1'b0);
        send_cmd(CMD_COUNT, 12'd4095, 1'b1);
        send_cmd(CMD_WRITE, 12'd1365, 1'b0);
        send_cmd(CMD_READ, 12'd1365, 1'b1);
    endtask

    // Sieve across the whole store, with a few cells already set
    task automatic test_full_sieve();
        send_cmd(CMD_SIEVE, '0, 1'b0);
        send_cmd(CMD_READ, 12'd4092, 1'b0);
        send_cmd(CMD_READ, 12'd4094, 1'b0);
        send_cmd(CMD_COUNT, '0, 1'b0);
    endtask

    // Empty, short and oversized lengths
    task automatic test_length_extremes();
        write_length(13'd0);
        send_cmd(CMD_WRITE, 12'd0, 1'b1);
        send_cmd(CMD_READ, 12'd0, 1'b0);
        send_cmd(CMD_COUNT, '0, 1'b0);
        send_cmd(CMD_SIEVE, '0, 1'b0);
        write_length(13'd1);
        send_cmd(CMD_SIEVE, '0, 1'b0);
        send_cmd(CMD_READ, 12'd1, 1'b0);
        write_length(13'd2);
        send_cmd(CMD_SIEVE, '0, 1'b0);
        // values above the store size saturate
        write_length(13'd8191);
        send_cmd(CMD_READ, 12'd4095, 1'b0);
        write_length(13'd4097);
        send_cmd(CMD_COUNT, '0, 1'b0);
    endtask

    // Clear a range, sieve it, read random cells back, count the composites
    task automatic test_sieve_runs(int unsigned rounds);
        int unsigned       len;
        int unsigned       k;
        logic [CFG_W-1:0]  len_bits;
        for (int r = 0; r < rounds; r++) begin
            len      = $urandom_range(8, 90);
            len_bits = CFG_W'(len);
            write_length(len_bits);
            for (k = 0; k < len; k++)
                send_cmd(CMD_WRITE, IDX_W'(k), 1'b0);
            send_cmd(CMD_SIEVE, IDX_W'($urandom_range(4095)), 1'($urandom_range(1)));
            for (k = 0; k < len / 2; k++)
                send_cmd(CMD_READ, IDX_W'($urandom_range(len - 1)),
                         1'($urandom_range(1)));
            send_cmd(CMD_COUNT, IDX_W'($urandom_range(4095)), 1'($urandom_range(1)));
        end
    endtask

    // Random commands over random lengths, mostly small ones
    task automatic test_random_mix(int unsigned segments, int unsigned per_segment);
        int unsigned       pick;
        int unsigned       heavy_pct;
        int unsigned       roll;
        logic [CFG_W-1:0]  len_bits;
        logic [IDX_W-1:0]  idx;
        for (int s = 0; s < segments; s++) begin
            pick = $urandom_range(15);
            if (pick == 0) len_bits = CFG_W'($urandom_range(4000, 8191));
            else if (pick == 1) len_bits = CFG_W'($urandom_range(3));
            else len_bits = CFG_W'($urandom_range(4, 600));
            write_length(len_bits);
            // whole-store walks are slow, keep them rare on long lengths
            heavy_pct = (length_mirror > 1024) ? 2 : 8;
            for (int i = 0; i < per_segment; i++) begin
                roll = $urandom_range(99);
                if (length_mirror > 0 && $urandom_range(9) < 8)
                    idx = IDX_W'($urandom_range(length_mirror - 1));
                else
                    idx = IDX_W'($urandom_range(4095));
                if (roll < heavy_pct)
                    send_cmd(CMD_COUNT, idx, 1'($urandom_range(1)));
                else if (roll < 2 * heavy_pct)
                    send_cmd(CMD_SIEVE, idx, 1'($urandom_range(1)));
                else if (roll < 50 + heavy_pct)
                    send_cmd(CMD_WRITE, idx, 1'($urandom_range(1)));
                else
                    send_cmd(CMD_READ, idx, 1'($urandom_range(1)));
            end
        end
    endtask

    // Receiver holds off while commands keep coming, so the input backs up
    task automatic test_output_backpressure();
        write_length(13'd256);
        set_idling(0, 0);
        hold_request = 300;
        for (int i = 0; i < 14; i++) begin
            if (i == 5) send_cmd(CMD_COUNT, '0, 1'b0);
            else send_cmd(i[0] ? CMD_READ : CMD_WRITE, IDX_W'($urandom_range(255)),
                          1'($urandom_range(1)));
        end
        wait_drained(8);
    endtask

    // Receiver ready: random stalls, or a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_request != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_request;
            hold_request  = 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Compare each result transaction against the oldest prediction
    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[0] !== want.read_bit) begin
                    error_count++;
                    $display("%0t: read_bit mismatch, expected %0d, got %0d",
                             $time, want.read_bit, m_axis_tdata[0]);
                end
                if (m_axis_tdata[13:1] !== want.tally) begin
                    error_count++;
                    $display("%0t: tally mismatch, expected %0d, got %0d",
                             $time, want.tally, m_axis_tdata[13:1]);
                end
                if (m_axis_tuser[0] !== want.status) begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_axis_tuser[0]);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bit_array_with_prime_sieve regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_WRITE;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        cell_mirror   = '0;
        length_mirror = BITS_DEF;
        error_count   = 0;
        hold_request  = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        set_idling(0, 0);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_field_extremes();
        test_full_sieve();
        test_length_extremes();
        test_sieve_runs(5);

        set_idling(0, 0);
        test_random_mix(5, 50);
        set_idling(67, 0);
        test_random_mix(5, 50);
        set_idling(0, 67);
        test_random_mix(5, 50);
        set_idling(9, 9);
        test_random_mix(5, 50);

        test_output_backpressure();

        wait_drained(40);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("bit_array_with_prime_sieve regression: pass");
        end else begin
            $display("bit_array_with_prime_sieve regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bas_pkg.sv
rtl/core/bas_store.sv
rtl/core/bas_divmod.sv
rtl/core/bas_seq.sv
rtl/core/bit_array_with_prime_sieve.sv
rtl/core/bas_checker.sv
bench/tb_bit_array_with_prime_sieve.sv
